// ===== rtl/core/bc1_bc2_bc3_block_decoder_core_macros.svh =====
// assertion macros shared by the block decoder checker
`ifndef BC1_BC2_BC3_BLOCK_DECODER_CORE_MACROS_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define BCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bcd_pkg.sv =====
// shared types, constants and helper functions of the block decoder
package bcd_pkg;

  // block format codes, any other code decodes as bc3
  localparam logic [1:0] MODE_BC1 = 2'd0;
  localparam logic [1:0] MODE_BC2 = 2'd1;

  localparam int TEXELS     = 16;
  localparam int TEXEL_W    = $clog2(TEXELS);
  localparam logic [TEXEL_W-1:0] LAST_TEXEL = TEXEL_W'(TEXELS - 1);

  // block queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // numerator width of interpolated channels
  localparam int NUM_W  = 11;
  localparam int PROD_W = NUM_W + 12;

  // reciprocal constants for exact floor division of numerators below 2048
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;
  localparam int RECIP5       = 1639;
  localparam int RECIP5_SHIFT = 13;
  localparam int RECIP7       = 2341;
  localparam int RECIP7_SHIFT = 14;

  typedef enum logic [2:0] {
    ALPHA_PALETTE,
    ALPHA_OPAQUE,
    ALPHA_EXPLICIT,
    ALPHA_INTERP8,
    ALPHA_INTERP6
  } alpha_kind_t;

  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_BY2,
    DIV_BY3,
    DIV_BY5,
    DIV_BY7
  } div_op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] color_half;
    logic [63:0] alpha_half;
  } bcd_in_t;

  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last_texel;
  } bcd_out_t;

  // classified block as it travels through the queue
  typedef struct packed {
    logic [31:0] color_idx;
    logic [63:0] alpha_code;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic        three_color;
    alpha_kind_t akind;
  } bcd_block_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor division by a small constant via reciprocal multiply
  function automatic logic [7:0] div_const(input logic [NUM_W-1:0] num, input div_op_t op);
    logic [PROD_W-1:0] prod;
    logic [7:0]        q;
    prod = '0;
    q    = '0;
    unique case (op)
      DIV_NONE: q = num[7:0];
      DIV_BY2:  q = num[8:1];
      DIV_BY3: begin
        prod = PROD_W'(num) * PROD_W'(RECIP3);
        q    = prod[RECIP3_SHIFT +: 8];
      end
      DIV_BY5: begin
        prod = PROD_W'(num) * PROD_W'(RECIP5);
        q    = prod[RECIP5_SHIFT +: 8];
      end
      DIV_BY7: begin
        prod = PROD_W'(num) * PROD_W'(RECIP7);
        q    = prod[RECIP7_SHIFT +: 8];
      end
      default: q = num[7:0];
    endcase
    return q;
  endfunction

endpackage

// ===== rtl/core/bcd_front.sv =====
// front end: takes a block word, widens endpoints and classifies the block
module bcd_front import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  bcd_in_t    blk,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       q_full,
  output logic       push,
  output bcd_block_t push_data
);

  logic       force_opaque;
  logic       held;
  bcd_block_t rec;
  bcd_block_t rec_next;
  logic       accept;
  logic [15:0] c0;
  logic [15:0] c1;

  // holding register frees up as soon as the queue takes it
  assign push      = held && !q_full;
  assign busy      = held && q_full;
  assign accept    = start && !busy;
  assign push_data = rec;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      force_opaque <= 1'b0;
    end else if (cfg_we) begin
      force_opaque <= cfg_wdata;
    end
  end

  // classify the incoming word
  always_comb begin
    c0 = blk.color_half[15:0];
    c1 = blk.color_half[31:16];
    rec_next.color_idx   = blk.color_half[63:32];
    rec_next.alpha_code  = blk.alpha_half;
    rec_next.r0          = widen5(c0[15:11]);
    rec_next.g0          = widen6(c0[10:5]);
    rec_next.b0          = widen5(c0[4:0]);
    rec_next.r1          = widen5(c1[15:11]);
    rec_next.g1          = widen6(c1[10:5]);
    rec_next.b1          = widen5(c1[4:0]);
    rec_next.a0          = blk.alpha_half[7:0];
    rec_next.a1          = blk.alpha_half[15:8];
    rec_next.three_color = (blk.mode == MODE_BC1) && (c0 <= c1);
    unique case (blk.mode)
      MODE_BC1: rec_next.akind = force_opaque ? ALPHA_OPAQUE : ALPHA_PALETTE;
      MODE_BC2: rec_next.akind = ALPHA_EXPLICIT;
      default:  rec_next.akind = (blk.alpha_half[7:0] > blk.alpha_half[15:8]) ?
                                 ALPHA_INTERP8 : ALPHA_INTERP6;
    endcase
  end

  // holding register control
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // holding register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rec <= rec_next;
    end
  end

endmodule

// ===== rtl/core/bcd_queue.sv =====
// short block queue between front and back
module bcd_queue import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bcd_block_t push_data,
  input  logic       pop,
  output bcd_block_t pop_data,
  output logic       full,
  output logic       empty
);

  bcd_block_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/bcd_back.sv =====
// back end: walks the sixteen texels of a block and interpolates each one
module bcd_back import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  bcd_block_t q_data,
  output logic       pop,
  output logic       strobe,
  output bcd_out_t   texel
);

  logic               active;
  logic [TEXEL_W-1:0] cnt;
  bcd_block_t         cur;

  // stage 1 registers: numerators and divide selects
  logic               s1_valid;
  logic [TEXEL_W-1:0] s1_index;
  logic [NUM_W-1:0]   s1_num_b;
  logic [NUM_W-1:0]   s1_num_g;
  logic [NUM_W-1:0]   s1_num_r;
  logic [NUM_W-1:0]   s1_num_a;
  div_op_t            s1_col_op;
  div_op_t            s1_alpha_op;

  logic [1:0]       ci;
  logic [3:0]       nib;
  logic [5:0]       abit;
  logic [2:0]       ai;
  logic [2:0]       k;
  logic [NUM_W-1:0] num_b;
  logic [NUM_W-1:0] num_g;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_a;
  div_op_t          col_op;
  div_op_t          alpha_op;

  // load the next block on the last texel or when idle
  assign pop = !q_empty && (!active || cnt == LAST_TEXEL);

  function automatic logic [NUM_W-1:0] chan_num(input logic [7:0] p0, input logic [7:0] p1,
                                                input logic [1:0] sel, input logic three);
    logic [NUM_W-1:0] n;
    n = '0;
    unique case (sel)
      2'd0: n = NUM_W'(p0);
      2'd1: n = NUM_W'(p1);
      2'd2: n = three ? NUM_W'(p0) + NUM_W'(p1)
                      : (NUM_W'(p0) << 1) + NUM_W'(p1) + 1'b1;
      2'd3: n = three ? '0 : NUM_W'(p0) + (NUM_W'(p1) << 1) + 1'b1;
      default: n = '0;
    endcase
    return n;
  endfunction

  // texel sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (cnt == LAST_TEXEL) begin
        active <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // current block
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // colour numerators for the selected palette entry
  always_comb begin
    ci     = cur.color_idx[{cnt, 1'b0} +: 2];
    num_b  = chan_num(cur.b0, cur.b1, ci, cur.three_color);
    num_g  = chan_num(cur.g0, cur.g1, ci, cur.three_color);
    num_r  = chan_num(cur.r0, cur.r1, ci, cur.three_color);
    col_op = DIV_NONE;
    if (ci[1]) begin
      if (!cur.three_color) begin
        col_op = DIV_BY3;
      end else if (!ci[0]) begin
        col_op = DIV_BY2;
      end
    end
  end

  // alpha numerator for the selected table entry
  always_comb begin
    nib      = cur.alpha_code[{cnt, 2'b00} +: 4];
    abit     = 6'd16 + 6'({cnt, 1'b0}) + 6'(cnt);
    ai       = cur.alpha_code[abit +: 3];
    k        = ai - 3'd1;
    num_a    = '0;
    alpha_op = DIV_NONE;
    unique case (cur.akind)
      ALPHA_OPAQUE:   num_a = NUM_W'(8'hFF);
      ALPHA_PALETTE:  num_a = (cur.three_color && ci == 2'd3) ? '0 : NUM_W'(8'hFF);
      ALPHA_EXPLICIT: num_a = NUM_W'({nib, nib});
      ALPHA_INTERP8: begin
        priority if (ai == 3'd0) begin
          num_a = NUM_W'(cur.a0);
        end else if (ai == 3'd1) begin
          num_a = NUM_W'(cur.a1);
        end else begin
          num_a    = NUM_W'(3'd7 - k) * NUM_W'(cur.a0) + NUM_W'(k) * NUM_W'(cur.a1)
                     + NUM_W'(3);
          alpha_op = DIV_BY7;
        end
      end
      ALPHA_INTERP6: begin
        priority if (ai == 3'd0) begin
          num_a = NUM_W'(cur.a0);
        end else if (ai == 3'd1) begin
          num_a = NUM_W'(cur.a1);
        end else if (ai == 3'd6) begin
          num_a = '0;
        end else if (ai == 3'd7) begin
          num_a = NUM_W'(8'hFF);
        end else begin
          num_a    = NUM_W'(3'd5 - k) * NUM_W'(cur.a0) + NUM_W'(k) * NUM_W'(cur.a1)
                     + NUM_W'(2);
          alpha_op = DIV_BY5;
        end
      end
      default: num_a = NUM_W'(8'hFF);
    endcase
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= active;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    s1_index    <= cnt;
    s1_num_b    <= num_b;
    s1_num_g    <= num_g;
    s1_num_r    <= num_r;
    s1_num_a    <= num_a;
    s1_col_op   <= col_op;
    s1_alpha_op <= alpha_op;
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s1_valid;
    end
  end

  // output word: divide and register
  always_ff @(posedge clk) begin
    texel.texel_index <= s1_index;
    texel.blue        <= div_const(s1_num_b, s1_col_op);
    texel.green       <= div_const(s1_num_g, s1_col_op);
    texel.red         <= div_const(s1_num_r, s1_col_op);
    texel.alpha       <= div_const(s1_num_a, s1_alpha_op);
    texel.last_texel  <= (s1_index == LAST_TEXEL);
  end

endmodule

// ===== rtl/core/bc1_bc2_bc3_block_decoder_core.sv =====
// top level of the bc1/bc2/bc3 texture block decoder
//
// Command channel: drive start with a compressed block on blk (mode, colour
// half, alpha half); the word is taken at a clock edge where start is high
// and busy is low. Configuration: cfg_we with cfg_wdata writes the bc1
// force-opaque bit; the user must write it only while the decoder is idle,
// which the block itself does not enforce.
// Result channel: each block gives sixteen texels in row-major order, one a
// cycle, each shown on texel for exactly one cycle with strobe high; the
// sixteenth carries last_texel. The receiver cannot stall the decoder.
// Path: the first texel passes the hold register, the queue, the block
// register with texel select, the numerator register and the divide register.
// Rate: set by the back-end texel sequencer, which emits one texel per cycle.
// Blocks sent faster wait in the hold register and a two-entry queue; busy
// rises only when both are full.
// Reset clears the queue, the sequencer and the force-opaque bit; no texel
// is shown until a block has been taken after reset.
module bc1_bc2_bc3_block_decoder_core import bcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  bcd_in_t  blk,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output logic     strobe,
  output bcd_out_t texel
);

  logic       push;
  bcd_block_t push_data;
  logic       pop;
  bcd_block_t pop_data;
  logic       q_full;
  logic       q_empty;

  // front end
  bcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .blk       (blk),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // block queue
  bcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // texel back end
  bcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .strobe  (strobe),
    .texel   (texel)
  );

endmodule

// ===== rtl/core/bcd_checker.sv =====
// port-level checker for the block decoder, bound to the top level
`include "bc1_bc2_bc3_block_decoder_core_macros.svh"

module bcd_checker import bcd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     strobe,
  input bcd_out_t texel
);

  // last flag only on the sixteenth texel
  `BCD_ASSERT_IMP(a_last_pos, strobe && texel.last_texel, texel.texel_index == LAST_TEXEL, "last_texel off the final texel")

  // texels of a block come out back to back in order
  `BCD_ASSERT_NXT(a_seq, strobe && !texel.last_texel, strobe && texel.texel_index == $past(texel.texel_index) + 1'b1, "texel sequence broken")

  // a burst always opens on the first texel
  `BCD_ASSERT_IMP(a_first, $rose(strobe), texel.texel_index == '0, "burst not starting at texel 0")

  // a taken block is followed by texels on strobe
  `BCD_ASSERT_IMP(a_latency, start && !busy, ##5 strobe, "no texel five cycles after block taken")

endmodule

bind bc1_bc2_bc3_block_decoder_core bcd_checker u_bcd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .texel  (texel)
);

// ===== verif/bcd_texel_checker.sv =====
// texel predictor and scoreboard for the bc1/bc2/bc3 block decoder
`timescale 1ns / 100ps

module bcd_texel_checker import bcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  bcd_in_t  blk,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     strobe,
  input  bcd_out_t texel,
  output int       mismatch_count,
  output int       pending_texels
);

  // shadow of the force-opaque register
  logic     force_opaque;
  bcd_out_t expected_texels[$];

  // rgb565 channel widening by bit replication
  function automatic int expand5(input logic [4:0] v);
    return (int'(v) << 3) | (int'(v) >> 2);
  endfunction

  function automatic int expand6(input logic [5:0] v);
    return (int'(v) << 2) | (int'(v) >> 4);
  endfunction

  // decode one block word into its sixteen expected texels
  function automatic void predict_block(input bcd_in_t b);
    logic [15:0] c0, c1;
    int          pr[4], pg[4], pb[4], pa[4], atab[8];
    int          a0, a1, ci, ai;
    bcd_out_t    t_out;
    c0 = b.color_half[15:0];
    c1 = b.color_half[31:16];
    pr[0] = expand5(c0[15:11]);
    pg[0] = expand6(c0[10:5]);
    pb[0] = expand5(c0[4:0]);
    pr[1] = expand5(c1[15:11]);
    pg[1] = expand6(c1[10:5]);
    pb[1] = expand5(c1[4:0]);
    pa = '{255, 255, 255, 255};

    // four-colour mode everywhere except bc1 with c0 <= c1
    if (c0 > c1 || b.mode != MODE_BC1) begin
      pr[2] = (2 * pr[0] + pr[1] + 1) / 3;
      pg[2] = (2 * pg[0] + pg[1] + 1) / 3;
      pb[2] = (2 * pb[0] + pb[1] + 1) / 3;
      pr[3] = (pr[0] + 2 * pr[1] + 1) / 3;
      pg[3] = (pg[0] + 2 * pg[1] + 1) / 3;
      pb[3] = (pb[0] + 2 * pb[1] + 1) / 3;
    end else begin
      pr[2] = (pr[0] + pr[1]) / 2;
      pg[2] = (pg[0] + pg[1]) / 2;
      pb[2] = (pb[0] + pb[1]) / 2;
      pr[3] = 0;
      pg[3] = 0;
      pb[3] = 0;
      pa[3] = 0;
    end

    // bc3 alpha table, eight-entry or six-entry form
    a0 = int'(b.alpha_half[7:0]);
    a1 = int'(b.alpha_half[15:8]);
    atab[0] = a0;
    atab[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) atab[k + 1] = ((7 - k) * a0 + k * a1 + 3) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) atab[k + 1] = ((5 - k) * a0 + k * a1 + 2) / 5;
      atab[6] = 0;
      atab[7] = 255;
    end

    for (int t = 0; t < TEXELS; t++) begin
      ci = int'(b.color_half[32 + 2 * t +: 2]);
      case (b.mode)
        MODE_BC1: ai = force_opaque ? 255 : pa[ci];
        MODE_BC2: ai = int'(b.alpha_half[4 * t +: 4]) * 17;
        default:  ai = atab[b.alpha_half[16 + 3 * t +: 3]];
      endcase
      t_out.texel_index = 4'(t);
      t_out.blue        = 8'(pb[ci]);
      t_out.green       = 8'(pg[ci]);
      t_out.red         = 8'(pr[ci]);
      t_out.alpha       = 8'(ai);
      t_out.last_texel  = (t == TEXELS - 1);
      expected_texels.push_back(t_out);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare one texel word against the oldest expectation
  function automatic void check_texel(input bcd_out_t got);
    bcd_out_t want;
    if (expected_texels.size() == 0) begin
      $error("texel with no block pending: %p", got);
      mismatch_count++;
      return;
    end
    want = expected_texels.pop_front();
    compare_field("texel_index", 8'(want.texel_index), 8'(got.texel_index));
    compare_field("blue", want.blue, got.blue);
    compare_field("green", want.green, got.green);
    compare_field("red", want.red, got.red);
    compare_field("alpha", want.alpha, got.alpha);
    compare_field("last_texel", 8'(want.last_texel), 8'(got.last_texel));
  endfunction

  // results first, then register writes, then newly taken block words
  always @(posedge clk) begin
    if (rst) begin
      force_opaque = 1'b0;
      expected_texels.delete();
    end else begin
      if (strobe !== 1'b0) check_texel(texel);
      if (cfg_we) force_opaque = cfg_wdata;
      if (start && !busy) predict_block(blk);
    end
    pending_texels = expected_texels.size();
  end

endmodule

// ===== verif/bc1_bc2_bc3_block_decoder_core_tb.sv =====
// stimulus and verdict for the bc1/bc2/bc3 block decoder
`timescale 1ns / 100ps

module bc1_bc2_bc3_block_decoder_core_tb;
  import bcd_pkg::*;

  localparam logic [1:0] MODE_BC3   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [47:0] ALL_AIDX = 48'hFAC688FAC688;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  bcd_in_t  blk;
  logic     cfg_we;
  logic     cfg_wdata;
  logic     strobe;
  bcd_out_t texel;
  int       mismatch_count;
  int       pending_texels;

  bc1_bc2_bc3_block_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .blk       (blk),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .strobe    (strobe),
    .texel     (texel)
  );

  bcd_texel_checker texel_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .blk            (blk),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .strobe         (strobe),
    .texel          (texel),
    .mismatch_count (mismatch_count),
    .pending_texels (pending_texels)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bcd_in_t make_block(input logic [1:0] m, input logic [63:0] ch,
                                         input logic [63:0] ah);
    bcd_in_t b;
    b.mode       = m;
    b.color_half = ch;
    b.alpha_half = ah;
    return b;
  endfunction

  // random block word, biased toward equal and extreme endpoints
  function automatic bcd_in_t random_block();
    bcd_in_t b;
    int      pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) b.mode = MODE_BC1;
    else if (pick < 6) b.mode = MODE_BC2;
    else if (pick < 9) b.mode = MODE_BC3;
    else b.mode = MODE_SPARE;
    b.color_half = {$urandom, $urandom};
    b.alpha_half = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: b.color_half[31:16] = b.color_half[15:0];
      1: b.color_half[31:0] = {16'h0000, 16'hFFFF};
      2: b.color_half[31:0] = {16'hFFFF, 16'h0000};
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: b.alpha_half[15:8] = b.alpha_half[7:0];
      1: b.alpha_half[15:0] = {8'h00, 8'hFF};
      2: b.alpha_half[15:0] = {8'hFF, 8'h00};
      default: ;
    endcase
    return b;
  endfunction

  // drive one block word after a gap, return at the falling edge after it is taken
  task automatic send_block(input bcd_in_t b, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    blk   <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every expected texel has come out
  task automatic drain();
    start <= 1'b0;
    while (pending_texels != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_force_opaque(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // random blocks with gap-free bursts and one mid-run drain
  task automatic run_random(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = (i % 40 < 12) ? 0 : $urandom_range(0, 3);
      if (i == count / 2) drain();
      send_block(random_block(), gap);
    end
    drain();
  endtask

  // bc1 corner blocks, repeated with force-opaque set
  task automatic send_bc1_corners();
    send_block(make_block(MODE_BC1, {32'hE4E4E4E4, 16'h001F, 16'hF800}, 64'h0),
               $urandom_range(0, 3));
    send_block(make_block(MODE_BC1, {32'h1B1B1B1B, 16'hF800, 16'h001F}, 64'h0),
               $urandom_range(0, 3));
    send_block(make_block(MODE_BC1, {32'hFFFFFFFF, 16'h7BEF, 16'h7BEF}, 64'h0),
               $urandom_range(0, 3));
    send_block(make_block(MODE_BC1, 64'h0, '1), $urandom_range(0, 3));
    send_block(make_block(MODE_BC1, '1, '1), $urandom_range(0, 3));
    send_block(make_block(MODE_BC1, {32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'h0),
               $urandom_range(0, 3));
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    blk       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed blocks, force-opaque clear
    write_force_opaque(1'b0);
    send_bc1_corners();
    send_block(make_block(MODE_BC2, {32'hE4E4E4E4, 16'hF800, 16'h001F},
                          64'hFEDCBA9876543210), $urandom_range(0, 3));
    send_block(make_block(MODE_BC2, 64'h0, 64'h0), $urandom_range(0, 3));
    send_block(make_block(MODE_BC2, '1, '1), $urandom_range(0, 3));
    send_block(make_block(MODE_BC3, {32'hE4E4E4E4, 16'h001F, 16'hF800},
                          {ALL_AIDX, 8'h00, 8'hFF}), $urandom_range(0, 3));
    send_block(make_block(MODE_BC3, {32'h1B1B1B1B, 16'hF800, 16'h001F},
                          {ALL_AIDX, 8'hFF, 8'h00}), $urandom_range(0, 3));
    send_block(make_block(MODE_BC3, {32'hE4E4E4E4, 16'h07E0, 16'h07E0},
                          {ALL_AIDX, 8'h80, 8'h80}), $urandom_range(0, 3));
    send_block(make_block(MODE_BC3, {32'h9C9C9C9C, 16'hFFFF, 16'h0001},
                          {ALL_AIDX, 8'hFE, 8'h01}), $urandom_range(0, 3));
    send_block(make_block(MODE_BC3, 64'h0, 64'h0), $urandom_range(0, 3));
    send_block(make_block(MODE_SPARE, {32'hE4E4E4E4, 16'h001F, 16'hF800},
                          {ALL_AIDX, 8'h00, 8'hFF}), $urandom_range(0, 3));
    send_block(make_block(MODE_SPARE, '1, '1), $urandom_range(0, 3));
    drain();

    // force-opaque set: bc1 alpha pinned, other formats untouched
    write_force_opaque(1'b1);
    send_bc1_corners();
    send_block(make_block(MODE_BC2, {32'hFFFFFFFF, 16'hFFFF, 16'h0000}, 64'h0), 0);
    send_block(make_block(MODE_BC3, {32'hFFFFFFFF, 16'hFFFF, 16'h0000},
                          {ALL_AIDX, 8'h10, 8'h20}), 0);
    drain();

    // random phases across register settings
    run_random(100);
    write_force_opaque(1'b0);
    run_random(100);
    write_force_opaque(1'b1);
    run_random(100);

    if (mismatch_count == 0 && pending_texels == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bcd_pkg.sv
rtl/core/bcd_front.sv
rtl/core/bcd_queue.sv
rtl/core/bcd_back.sv
rtl/core/bc1_bc2_bc3_block_decoder_core.sv
rtl/core/bcd_checker.sv
verif/bcd_texel_checker.sv
verif/bc1_bc2_bc3_block_decoder_core_tb.sv
